/* hdl/rwh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwh_pkg: shared constants, types and helpers for random_walk_histogram
// Sizes of the histogram memories, field widths, request and register codes,
// control-unit states and the command/status bundles of the histogram unit.
// ----------------------------------------------------------------------------
package rwh_pkg;

   // sizing
   localparam int MAX_STEPS   = 1024;
   localparam int COUNT_BITS  = 32;
   localparam int POS_BINS    = 2 * MAX_STEPS + 1;
   localparam int MAG_BINS    = MAX_STEPS + 1;
   localparam int POS_AW      = $clog2(POS_BINS);
   localparam int MAG_AW      = $clog2(MAG_BINS);
   localparam int POS_W       = MAG_AW + 1;           // signed walk position
   localparam int STEP_CNT_W  = $clog2(MAX_STEPS + 1);

   // generator
   localparam int GEN_W  = 64;
   localparam int HALF_W = GEN_W / 2;

   // configuration
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int STEPS_REG_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_MULT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS = 2'd2;
   localparam logic [GEN_W-1:0]       MULT_RESET  = 64'd1181783497276652981;
   localparam logic [GEN_W-1:0]       SEED_RESET  = 64'd131419;
   localparam logic [STEPS_REG_W-1:0] STEPS_RESET = 11'd1000;

   // request channel
   localparam int REQ_W       = 2;
   localparam int IDX_W       = 12;
   localparam int REQ_TDATA_W = 16;
   localparam logic [REQ_W-1:0] REQ_RUN     = 2'd0;
   localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

   // result channel
   localparam int FPOS_W       = 12;
   localparam int OUT_CNT_W    = 32;
   localparam int SQ_W         = 23;
   localparam int RSP_FIELDS_W = FPOS_W + 2 * OUT_CNT_W + SQ_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_WALK,
      ST_BUMP,
      ST_RD_ISSUE,
      ST_RD_WAIT,
      ST_RESTART,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      HOP_IDLE,
      HOP_READ,
      HOP_BUMP,
      HOP_CLEAR
   } hist_op_type;

   typedef struct packed {
      hist_op_type       op;
      logic [POS_AW-1:0] pos_addr;
      logic              pos_en;
      logic [MAG_AW-1:0] mag_addr;
      logic              mag_en;
   } hist_cmd_type;

   typedef struct packed {
      logic                  clr_busy;
      logic [COUNT_BITS-1:0] pos_count;
      logic [COUNT_BITS-1:0] mag_count;
   } hist_sts_type;

   // saturating counter increment
   function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] v);
      if (v == {COUNT_BITS{1'b1}}) begin
         return v;
      end
      return v + 1'b1;
   endfunction

   // clamp a counter to the output width
   function automatic logic [OUT_CNT_W-1:0] count_sat(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS+OUT_CNT_W-1:0] wide;
      wide = (COUNT_BITS+OUT_CNT_W)'(v);
      if ((wide >> OUT_CNT_W) != '0) begin
         return {OUT_CNT_W{1'b1}};
      end
      return wide[OUT_CNT_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* hdl/rwh_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwh_mul: generator step, state times multiplier modulo 2^64
// One shared 32x32 multiplier, three passes per product: low x low, then the
// two cross terms folded into the upper half. Only the low 64 bits are kept.
// ----------------------------------------------------------------------------
module rwh_mul (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic [rwh_pkg::GEN_W-1:0] a,
   input  wire logic [rwh_pkg::GEN_W-1:0] b,
   output logic                          done,
   output logic [rwh_pkg::GEN_W-1:0]     prod
);
   import rwh_pkg::*;

   localparam logic [1:0] PH_LO      = 2'd0;
   localparam logic [1:0] PH_CROSS_A = 2'd1;
   localparam logic [1:0] PH_CROSS_B = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [GEN_W-1:0]  acc_ff, acc_in;
   logic [HALF_W-1:0] op_x, op_y;
   logic [GEN_W-1:0]  mp;

   always_comb begin
      case (phase_ff)
         PH_CROSS_A: begin
            op_x = a[GEN_W-1:HALF_W];
            op_y = b[HALF_W-1:0];
         end
         PH_CROSS_B: begin
            op_x = a[HALF_W-1:0];
            op_y = b[GEN_W-1:HALF_W];
         end
         default: begin
            op_x = a[HALF_W-1:0];
            op_y = b[HALF_W-1:0];
         end
      endcase
   end

   assign mp = GEN_W'(op_x) * GEN_W'(op_y);

   always_comb begin
      if (phase_ff == PH_LO) begin
         acc_in = mp;
      end else begin
         acc_in = {acc_ff[GEN_W-1:HALF_W] + mp[HALF_W-1:0], acc_ff[HALF_W-1:0]};
      end
   end

   assign done = en && (phase_ff == PH_CROSS_B);
   assign prod = acc_in;

   always_comb begin
      if (!en || phase_ff == PH_CROSS_B) begin
         phase_in = PH_LO;
      end else begin
         phase_in = phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LO;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule
`default_nettype wire

/* hdl/rwh_hist.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwh_hist: position and magnitude histogram memories
// Registered reads, read-modify-write bump with saturation, and a clearing
// sweep of one entry per cycle after reset or on a clear command.
// ----------------------------------------------------------------------------
module rwh_hist (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rwh_pkg::hist_cmd_type cmd,
   output rwh_pkg::hist_sts_type      sts
);
   import rwh_pkg::*;

   logic [COUNT_BITS-1:0] pos_mem [POS_BINS];
   logic [COUNT_BITS-1:0] mag_mem [MAG_BINS];

   logic [COUNT_BITS-1:0] rd_pos_ff, rd_mag_ff;
   logic [POS_AW-1:0]     wr_pos_addr_ff;
   logic [MAG_AW-1:0]     wr_mag_addr_ff;
   logic                  bump_ff, bump_in;
   logic                  clr_busy_ff, clr_busy_in;
   logic [POS_AW-1:0]     clr_addr_ff, clr_addr_in;
   logic                  pos_rd, mag_rd, mag_clr;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (cmd.op == HOP_CLEAR) begin
         clr_busy_in = 1'b1;
         clr_addr_in = '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == POS_AW'(POS_BINS - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   assign bump_in = (cmd.op == HOP_BUMP);
   assign pos_rd  = bump_in || (cmd.op == HOP_READ && cmd.pos_en);
   assign mag_rd  = bump_in || (cmd.op == HOP_READ && cmd.mag_en);
   assign mag_clr = clr_busy_ff && (clr_addr_ff < POS_AW'(MAG_BINS));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         bump_ff     <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         bump_ff     <= bump_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bump_in) begin
         wr_pos_addr_ff <= cmd.pos_addr;
         wr_mag_addr_ff <= cmd.mag_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         pos_mem[clr_addr_ff] <= '0;
      end else if (bump_ff) begin
         pos_mem[wr_pos_addr_ff] <= count_inc(rd_pos_ff);
      end
      if (pos_rd) begin
         rd_pos_ff <= pos_mem[cmd.pos_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mag_clr) begin
         mag_mem[MAG_AW'(clr_addr_ff)] <= '0;
      end else if (bump_ff) begin
         mag_mem[wr_mag_addr_ff] <= count_inc(rd_mag_ff);
      end
      if (mag_rd) begin
         rd_mag_ff <= mag_mem[cmd.mag_addr];
      end
   end

   assign sts.clr_busy  = clr_busy_ff;
   assign sts.pos_count = rd_pos_ff;
   assign sts.mag_count = rd_mag_ff;

endmodule
`default_nettype wire

/* hdl/random_walk_histogram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// random_walk_histogram: 1-D random-walk Monte Carlo engine
// Runs walks driven by a 64-bit multiplicative generator and keeps saturating
// histograms of the final position and of its magnitude.
// ----------------------------------------------------------------------------
// One request is worked at a time; a result waiting on the rsp side does not
// block the next req transfer. Request kind is req_tuser: run (0), read (1),
// restart (2); code 3 returns an all-zero result. In a run, each step is
// one 64-bit generator product built in three passes of a single 32x32
// multiplier, and the two histogram bins are then bumped by a
// read-modify-write of the two memories. A read makes one registered memory
// read. A restart reloads the generator from seed_value and sweeps both
// memories to zero, one entry per cycle. The same clearing pass runs after
// reset, during which no req transfer is taken (csr writes are taken as
// ever). csr writes belong in idle time only.
// ----------------------------------------------------------------------------
module random_walk_histogram (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration
   input  wire logic                              csr_wr_en,
   input  wire logic [rwh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rwh_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [rwh_pkg::REQ_TDATA_W-1:0]   req_tdata,   // bin_index, zero pad
   input  wire logic [rwh_pkg::REQ_W-1:0]         req_tuser,   // req_type
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [rwh_pkg::RSP_TDATA_W-1:0]        rsp_tdata    // final_position,
                                                               // position_count,
                                                               // magnitude_count,
                                                               // square_index, pad
);
   import rwh_pkg::*;

   localparam int FPOS_MAX = 2 ** (FPOS_W - 1) - 1;
   localparam int FPOS_MIN = -(2 ** (FPOS_W - 1));
   localparam int SQ_FULL_W = 2 * IDX_W;
   localparam logic [SQ_FULL_W-1:0] SQ_MAX = SQ_FULL_W'(2 ** SQ_W - 1);

   // config registers
   logic [GEN_W-1:0]       mult_ff;
   logic [GEN_W-1:0]       seed_ff;
   logic [STEPS_REG_W-1:0] steps_ff;

   // control / datapath
   state_type               state_ff, state_in;
   logic [GEN_W-1:0]        gen_ff, gen_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic [STEP_CNT_W-1:0]   steps_left_ff, steps_left_in, steps_eff;
   logic [REQ_W-1:0]        req_type_ff, req_type_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [FPOS_W-1:0] rsp_fpos_ff, rsp_fpos_in;
   logic [OUT_CNT_W-1:0]     rsp_pcnt_ff, rsp_pcnt_in;
   logic [OUT_CNT_W-1:0]     rsp_mcnt_ff, rsp_mcnt_in;
   logic [SQ_W-1:0]          rsp_sq_ff, rsp_sq_in;

   logic                 req_xfer, rsp_load;
   logic                 mul_en, mul_done;
   logic [GEN_W-1:0]     mul_prod;
   hist_cmd_type         hcmd;
   hist_sts_type         hsts;
   logic                 pos_ok, mag_ok;
   logic [SQ_FULL_W-1:0] sq_full;
   int                   pos_int, fpos_int;

   rwh_mul u_mul (
      .clock (clock),
      .reset (reset),
      .en    (mul_en),
      .a     (gen_ff),
      .b     (mult_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   rwh_hist u_hist (
      .clock (clock),
      .reset (reset),
      .cmd   (hcmd),
      .sts   (hsts)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   // output register free, or being drained this cycle
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // walk length, clamped to the histogram span
   always_comb begin
      if (32'(steps_ff) > MAX_STEPS) begin
         steps_eff = STEP_CNT_W'(MAX_STEPS);
      end else begin
         steps_eff = STEP_CNT_W'(steps_ff);
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff  <= MULT_RESET;
         seed_ff  <= SEED_RESET;
         steps_ff <= STEPS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MULT:  mult_ff  <= csr_wdata;
            CSR_SEED:  seed_ff  <= csr_wdata;
            CSR_STEPS: steps_ff <= csr_wdata[STEPS_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (!hsts.clr_busy) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_tuser)
                  REQ_RUN:     state_in = (steps_eff == '0) ? ST_BUMP : ST_WALK;
                  REQ_READ:    state_in = ST_RD_ISSUE;
                  REQ_RESTART: state_in = ST_RESTART;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK: begin
            if (mul_done && steps_left_ff == STEP_CNT_W'(1)) state_in = ST_BUMP;
         end
         ST_BUMP:     state_in = ST_DONE;
         ST_RD_ISSUE: state_in = ST_RD_WAIT;
         ST_RD_WAIT:  state_in = ST_DONE;
         ST_RESTART:  state_in = ST_CLEAR;
         ST_CLEAR: begin
            // clear busy is already up the cycle after the command
            if (!hsts.clr_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // read-side helpers
   assign pos_ok  = 32'(idx_ff) < POS_BINS;
   assign mag_ok  = 32'(idx_ff) < MAG_BINS;
   assign sq_full = SQ_FULL_W'(idx_ff) * SQ_FULL_W'(idx_ff);
   assign pos_int = int'(pos_ff);

   always_comb begin
      if (pos_int > FPOS_MAX) begin
         fpos_int = FPOS_MAX;
      end else if (pos_int < FPOS_MIN) begin
         fpos_int = FPOS_MIN;
      end else begin
         fpos_int = pos_int;
      end
   end

   // datapath and outputs
   always_comb begin
      gen_in        = gen_ff;
      pos_in        = pos_ff;
      steps_left_in = steps_left_ff;
      req_type_in   = req_type_ff;
      idx_in        = idx_ff;
      mul_en        = 1'b0;
      hcmd          = '{op: HOP_IDLE, pos_addr: '0, pos_en: 1'b0, mag_addr: '0, mag_en: 1'b0};
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_pcnt_in   = rsp_pcnt_ff;
      rsp_mcnt_in   = rsp_mcnt_ff;
      rsp_sq_in     = rsp_sq_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               req_type_in   = req_tuser;
               idx_in        = req_tdata[IDX_W-1:0];
               pos_in        = '0;
               steps_left_in = steps_eff;
            end
         end
         ST_WALK: begin
            mul_en = 1'b1;
            if (mul_done) begin
               // top bit of the new state picks the step direction
               gen_in        = mul_prod;
               pos_in        = mul_prod[GEN_W-1] ? pos_ff - POS_W'(1) : pos_ff + POS_W'(1);
               steps_left_in = steps_left_ff - 1'b1;
            end
         end
         ST_BUMP: begin
            hcmd.op       = HOP_BUMP;
            hcmd.pos_addr = POS_AW'(pos_int + MAX_STEPS);
            hcmd.pos_en   = 1'b1;
            hcmd.mag_addr = MAG_AW'((pos_int < 0) ? -pos_int : pos_int);
            hcmd.mag_en   = 1'b1;
         end
         ST_RD_ISSUE: begin
            // out-of-range bins are not read, they report zero
            hcmd.op       = HOP_READ;
            hcmd.pos_addr = POS_AW'(idx_ff);
            hcmd.pos_en   = pos_ok;
            hcmd.mag_addr = MAG_AW'(idx_ff);
            hcmd.mag_en   = mag_ok;
         end
         ST_RESTART: begin
            hcmd.op = HOP_CLEAR;
            gen_in  = seed_ff;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_fpos_in = '0;
               rsp_pcnt_in = '0;
               rsp_mcnt_in = '0;
               rsp_sq_in   = '0;
               if (req_type_ff == REQ_RUN) begin
                  rsp_fpos_in = FPOS_W'(fpos_int);
               end else if (req_type_ff == REQ_READ) begin
                  if (pos_ok) rsp_pcnt_in = count_sat(hsts.pos_count);
                  if (mag_ok) rsp_mcnt_in = count_sat(hsts.mag_count);
                  rsp_sq_in = (sq_full > SQ_MAX) ? {SQ_W{1'b1}} : sq_full[SQ_W-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         gen_ff       <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      steps_left_ff <= steps_left_in;
      req_type_ff   <= req_type_in;
      idx_ff        <= idx_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_pcnt_ff   <= rsp_pcnt_in;
      rsp_mcnt_ff   <= rsp_mcnt_in;
      rsp_sq_ff     <= rsp_sq_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}},
                        rsp_sq_ff, rsp_mcnt_ff, rsp_pcnt_ff, rsp_fpos_ff};

endmodule
`default_nettype wire

/* dv/random_walk_histogram_tb.sv */
// ----------------------------------------------------------------------------
// random_walk_histogram_tb: self-checking bench for the random-walk engine
// A queue-fed driver sends run, read, restart and unused requests while a
// shadow model of the generator and both histograms predicts every result.
// The monitor checks each result transfer against the oldest prediction.
// Traffic runs under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module random_walk_histogram_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rwh_pkg::*;

   // request code the block must answer with an all-zero result
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int HOLD_CYCLES = 400;    // long receiver hold-off
   localparam int TAIL_CYCLES = 40;     // quiet time before the verdict
   localparam int MAX_LOGGED  = 30;

   typedef struct packed {
      logic [REQ_W-1:0] kind;
      logic [IDX_W-1:0] bin_idx;
   } walk_request_type;

   // first declared field sits in the upper bits of the packed vector
   typedef struct packed {
      logic [SQ_W-1:0]      square_index;
      logic [OUT_CNT_W-1:0] magnitude_count;
      logic [OUT_CNT_W-1:0] position_count;
      logic [FPOS_W-1:0]    final_position;
   } walk_result_type;

   // DUT inputs, all known from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // bin_index, zero pad
   logic [REQ_W-1:0]       req_tuser = '0;   // req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // final_position, position_count,
                                             // magnitude_count, square_index, pad

   // bench state
   walk_request_type request_backlog[$];
   walk_result_type  results_due[$];
   int               mismatches = 0;
   int               cycle_count = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               hold_left;
   logic             hold_start = 1'b0;

   // shadow copy of the engine
   logic [GEN_W-1:0]       mdl_mult;
   logic [GEN_W-1:0]       mdl_seed;
   logic [STEPS_REG_W-1:0] mdl_steps;
   logic [GEN_W-1:0]       mdl_gen;
   logic [COUNT_BITS-1:0]  mdl_pos_hist [POS_BINS];
   logic [COUNT_BITS-1:0]  mdl_mag_hist [MAG_BINS];

   random_walk_histogram dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one printed line per bad result, counting goes on after the log goes quiet
   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_LOGGED) begin
         $display("[%0t] MISMATCH: %s", $time, what);
      end
   endtask

   // Predicts the result of one accepted request and advances the shadow state.
   task automatic predict_walk_result(input logic [REQ_W-1:0] kind,
                                      input logic [IDX_W-1:0] bin_idx);
      walk_result_type r;
      int              n;
      int              pos;
      int              mag;
      int              sq;
      r = '0;
      case (kind)
         REQ_RUN: begin
            n   = (int'(mdl_steps) > MAX_STEPS) ? MAX_STEPS : int'(mdl_steps);
            pos = 0;
            for (int i = 0; i < n; i++) begin
               mdl_gen = mdl_gen * mdl_mult;   // wraps mod 2^64
               pos     = mdl_gen[GEN_W-1] ? pos - 1 : pos + 1;
            end
            mag = (pos < 0) ? -pos : pos;
            if (mdl_pos_hist[pos + MAX_STEPS] != '1) begin
               mdl_pos_hist[pos + MAX_STEPS]++;
            end
            if (mdl_mag_hist[mag] != '1) begin
               mdl_mag_hist[mag]++;
            end
            r.final_position = FPOS_W'(pos);   // |pos| <= 1024, always fits
         end
         REQ_READ: begin
            if (int'(bin_idx) < POS_BINS) begin
               r.position_count = OUT_CNT_W'(mdl_pos_hist[bin_idx]);
            end
            if (int'(bin_idx) < MAG_BINS) begin
               r.magnitude_count = OUT_CNT_W'(mdl_mag_hist[bin_idx]);
            end
            sq = int'(bin_idx) * int'(bin_idx);
            r.square_index = (sq > 2 ** SQ_W - 1) ? '1 : SQ_W'(sq);
         end
         REQ_RESTART: begin
            mdl_gen = mdl_seed;
            foreach (mdl_pos_hist[i]) mdl_pos_hist[i] = '0;
            foreach (mdl_mag_hist[i]) mdl_mag_hist[i] = '0;
         end
         default: ;   // unused code: nothing moves, all-zero result
      endcase
      results_due.push_back(r);
   endtask

   // ---------------------------------------------------------------- driver
   // Predicts on every accepted transfer; a new item (or an idle cycle) is
   // only put on the bus once the current one is gone.
   always @(posedge clock) begin
      walk_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_walk_result(req_tuser, req_tdata[IDX_W-1:0]);
         end
         if (!req_tvalid || req_tready) begin
            if (request_backlog.size() != 0 &&
                $urandom_range(99, 0) >= send_idle_pct) begin
               item = request_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= item.kind;
               req_tdata  <= {{(REQ_TDATA_W - IDX_W){1'b0}}, item.bin_idx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long hold-off on the result side, timed on its own
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin
      walk_result_type got;
      walk_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = walk_result_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
            if (results_due.size() == 0) begin
               report_mismatch("result transfer with no request outstanding");
            end else begin
               want = results_due.pop_front();
               if (got !== want) begin
                  report_mismatch($sformatf(
                     "got pos %0d cnt %0d/%0d sq %0d, want pos %0d cnt %0d/%0d sq %0d",
                     $signed(got.final_position), got.position_count,
                     got.magnitude_count, got.square_index,
                     $signed(want.final_position), want.position_count,
                     want.magnitude_count, want.square_index));
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[%0t] timeout after %0d cycles", $time, cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------- stimulus
   task automatic queue_request(input logic [REQ_W-1:0] kind,
                                input int bin_idx);
      request_backlog.push_back('{kind, IDX_W'(bin_idx)});
   endtask

   // registers are written one per cycle; shadow copy follows right away
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MULT:  mdl_mult  = val;
         CSR_SEED:  mdl_seed  = val;
         CSR_STEPS: mdl_steps = val[STEPS_REG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_walk_config(input logic [GEN_W-1:0] mult,
                                   input logic [GEN_W-1:0] seed,
                                   input int steps);
      write_reg(CSR_MULT, mult);
      write_reg(CSR_SEED, seed);
      write_reg(CSR_STEPS, CSR_DATA_W'(steps));
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // sender stays quiet until every result of the queued work is back
   task automatic wait_drained();
      do @(posedge clock);
      while (request_backlog.size() != 0 || req_tvalid || results_due.size() != 0);
   endtask

   // One register setting: restart, then a random mix. Reads mostly aim at
   // bins the walks can reach so that nonzero counts get checked.
   task automatic run_setting(input logic [GEN_W-1:0] mult,
                              input logic [GEN_W-1:0] seed,
                              input int steps, input int count,
                              input int send_pct, input int recv_pct);
      int span;
      int pick;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      load_walk_config(mult, seed, steps);
      span = (steps > MAX_STEPS) ? MAX_STEPS : steps;
      queue_request(REQ_RESTART, $urandom_range(4095, 0));
      repeat (count) begin
         pick = $urandom_range(99, 0);
         if (pick < 3) begin
            queue_request(REQ_RESTART, $urandom_range(4095, 0));
         end else if (pick < 8) begin
            queue_request(REQ_UNUSED, $urandom_range(4095, 0));
         end else if (pick < 55) begin
            queue_request(REQ_RUN, $urandom_range(4095, 0));
         end else if (pick < 75) begin
            queue_request(REQ_READ, MAX_STEPS + int'($urandom_range(2 * span, 0)) - span);
         end else if (pick < 88) begin
            queue_request(REQ_READ, $urandom_range(span, 0));
         end else begin
            queue_request(REQ_READ, $urandom_range(4095, 0));
         end
      end
      wait_drained();
   endtask

   initial begin
      // shadow state matches the block after reset
      mdl_mult  = MULT_RESET;
      mdl_seed  = SEED_RESET;
      mdl_steps = STEPS_RESET;
      mdl_gen   = SEED_RESET;
      foreach (mdl_pos_hist[i]) mdl_pos_hist[i] = '0;
      foreach (mdl_mag_hist[i]) mdl_mag_hist[i] = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset registers: empty bins, index extremes, square clamp, unused code,
      // then two full-length walks and reads around the origin
      queue_request(REQ_READ, 0);
      queue_request(REQ_READ, 2 * MAX_STEPS);
      queue_request(REQ_READ, 4095);
      queue_request(REQ_READ, 2896);        // largest unclamped square
      queue_request(REQ_READ, 2897);        // first clamped square
      queue_request(REQ_UNUSED, 4095);
      queue_request(REQ_RUN, 0);
      queue_request(REQ_RUN, 4095);
      queue_request(REQ_READ, MAX_STEPS);
      queue_request(REQ_READ, MAX_STEPS - 2);
      queue_request(REQ_READ, MAX_STEPS + 2);
      wait_drained();

      // generator stuck at zero, step count above the cap: walk ends at +MAX_STEPS
      load_walk_config(64'd1, 64'd0, 2 ** STEPS_REG_W - 1);
      queue_request(REQ_RESTART, 0);
      queue_request(REQ_RUN, 0);
      queue_request(REQ_READ, 2 * MAX_STEPS);
      queue_request(REQ_READ, MAX_STEPS);
      queue_request(REQ_READ, MAX_STEPS + 1);   // magnitude bin out of range
      wait_drained();

      // top bit stuck at one: walk ends at -MAX_STEPS
      load_walk_config(64'd1, 64'h8000_0000_0000_0000, MAX_STEPS);
      queue_request(REQ_RESTART, 0);
      queue_request(REQ_RUN, 0);
      queue_request(REQ_READ, 0);
      wait_drained();

      // zero steps: walk stays home, bins still counted
      load_walk_config(MULT_RESET, SEED_RESET, 0);
      queue_request(REQ_RUN, 0);
      queue_request(REQ_RUN, 0);
      queue_request(REQ_READ, MAX_STEPS);
      queue_request(REQ_READ, 0);
      wait_drained();

      // receiver holds off while the sender keeps offering: input must stall
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      run_setting(MULT_RESET, {$urandom, $urandom}, 8, 80, 0, 0);

      run_setting('1, {$urandom, $urandom}, 1, 70, 87, 0);
      run_setting({$urandom, $urandom} | 64'd1, {$urandom, $urandom}, 16, 70, 87, 0);
      run_setting('0, {$urandom, $urandom}, 5, 70, 0, 87);
      run_setting({$urandom, $urandom}, '1, MAX_STEPS, 12, 0, 87);
      run_setting({$urandom, $urandom}, {$urandom, $urandom}, 3, 80, 12, 12);
      run_setting({$urandom, $urandom}, {$urandom, $urandom},
                  $urandom_range(64, 1), 80, 12, 12);
      run_setting(MULT_RESET, SEED_RESET, 12, 90, 0, 0);

      // stray results would show up here
      recv_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (results_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", results_due.size()));
      end
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
